// ===== rtl/gsw_pkg.sv =====
// Shared types and constants of the trilinear grid shape weight block.
package gsw_pkg;

    localparam int CELL_W   = 11;
    localparam int CIDX_W   = 10;
    localparam int FRAC_W   = 16;
    localparam int POS_W    = 32;
    localparam int INV_W    = 32;
    localparam int ELEM_W   = 30;
    localparam int NODE_W   = 31;
    localparam int CORNER_W = 3;
    localparam int WEIGHT_W = 17;
    localparam int GRAD_W   = 32;
    localparam int NAXES    = 3;
    localparam int CXY_W    = 21;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [2:0] REG_CELLS_X = 3'd0;
    localparam logic [2:0] REG_CELLS_Y = 3'd1;
    localparam logic [2:0] REG_CELLS_Z = 3'd2;
    localparam logic [2:0] REG_INV_X   = 3'd3;
    localparam logic [2:0] REG_INV_Y   = 3'd4;
    localparam logic [2:0] REG_INV_Z   = 3'd5;

    typedef struct packed {
        logic [NAXES-1:0][CELL_W-1:0] eff_cells;
        logic [NAXES-1:0][INV_W-1:0]  inv;
        logic [CXY_W-1:0]             cxy;
        logic [CELL_W-1:0]            sx1;
        logic [CXY_W-1:0]             sxy1;
    } gsw_cfg_t;

    typedef struct packed {
        logic                         in_grid;
        logic [NAXES-1:0][FRAC_W-1:0] frac;
        logic [ELEM_W-1:0]            elem;
        logic [NODE_W-1:0]            node_base;
    } gsw_item_t;

    typedef struct packed {
        logic                         in_domain;
        logic [ELEM_W-1:0]            element_id;
        logic [CORNER_W-1:0]          corner;
        logic [NODE_W-1:0]            node_id;
        logic [WEIGHT_W-1:0]          weight;
        logic [NAXES-1:0][GRAD_W-1:0] grad;
        logic                         last;
    } gsw_result_t;

endpackage

// ===== rtl/trilinear_grid_shape_weights.sv =====
// Top level: register port, front pipeline, item queue, corner back end, result queue.
//
//  channel  | dir | handshake                 | beat
//  ---------+-----+---------------------------+--------------------------------------
//  config   | in  | psel/penable/pwrite/pready| one register write or read
//  position | in  | push / full               | pos_x, pos_y, pos_z
//  result   | out | pop / empty               | in_domain ... grad_z, last
//
// The back end issues one corner per cycle while the result queue has room: an inside
// position gives 2^DIMS corner beats, an outside one a single beat; positions are taken
// every cycle while the item queue has room. A position passes three front stages, the item
// queue, two back stages and the result queue before its first result beat reaches the ports.
// Reset restores register defaults and empties both queues.
// With pop low the result queue fills, the back end holds, the item queue fills and full rises.
module trilinear_grid_shape_weights import gsw_pkg::*; #(
    parameter int DIMS      = 3,
    parameter int MAX_CELLS = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  logic                     push,
    output logic                     full,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic signed [POS_W-1:0]  pos_z,
    input  logic                     pop,
    output logic                     empty,
    output logic                     in_domain,
    output logic [ELEM_W-1:0]        element_id,
    output logic [CORNER_W-1:0]      corner,
    output logic [NODE_W-1:0]        node_id,
    output logic [WEIGHT_W-1:0]      weight,
    output logic signed [GRAD_W-1:0] grad_x,
    output logic signed [GRAD_W-1:0] grad_y,
    output logic signed [GRAD_W-1:0] grad_z,
    output logic                     last
);

    localparam int ITEM_W = $bits(gsw_item_t);
    localparam int RES_W  = $bits(gsw_result_t);

    logic [NAXES-1:0][CELL_W-1:0] cells_reg;
    logic [NAXES-1:0][INV_W-1:0]  inv_reg;
    logic [CXY_W-1:0]             cxy_reg, cxy_next;
    logic [CXY_W-1:0]             sxy1_reg, sxy1_next;
    logic [NAXES-1:0][CELL_W-1:0] eff_cells;
    logic [2:0]                   reg_idx;
    logic                         wr_en;
    gsw_cfg_t                     cfg;

    logic        item_push, item_full, q_empty, q_pop;
    gsw_item_t   item, q_item;
    logic        o_push, o_full;
    gsw_result_t o_res, res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        for (int d = 0; d < NAXES; d++)
        begin
            eff_cells[d] = (cells_reg[d] > CELL_W'(MAX_CELLS)) ? CELL_W'(MAX_CELLS)
                                                               : cells_reg[d];
        end
        cxy_next  = CXY_W'(22'(eff_cells[0]) * 22'(eff_cells[1]));
        sxy1_next = CXY_W'(22'(eff_cells[0] + 1'b1) * 22'(eff_cells[1] + 1'b1));
        cfg.eff_cells = eff_cells;
        cfg.inv       = inv_reg;
        cfg.cxy       = cxy_reg;
        cfg.sx1       = eff_cells[0] + 1'b1;
        cfg.sxy1      = sxy1_reg;
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CELLS_X: prdata = DATA_W'(cells_reg[0]);
            REG_CELLS_Y: prdata = DATA_W'(cells_reg[1]);
            REG_CELLS_Z: prdata = DATA_W'(cells_reg[2]);
            REG_INV_X:   prdata = inv_reg[0];
            REG_INV_Y:   prdata = inv_reg[1];
            REG_INV_Z:   prdata = inv_reg[2];
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells_reg <= {NAXES{CELL_W'(1)}};
            inv_reg   <= {NAXES{32'h00010000}};
            cxy_reg   <= CXY_W'(1);
            sxy1_reg  <= CXY_W'(4);
        end
        else
        begin
            cxy_reg  <= cxy_next;
            sxy1_reg <= sxy1_next;
            if (wr_en)
            begin
                unique case (reg_idx)
                    REG_CELLS_X: cells_reg[0] <= pwdata[CELL_W-1:0];
                    REG_CELLS_Y: cells_reg[1] <= pwdata[CELL_W-1:0];
                    REG_CELLS_Z: cells_reg[2] <= pwdata[CELL_W-1:0];
                    REG_INV_X:   inv_reg[0]   <= pwdata;
                    REG_INV_Y:   inv_reg[1]   <= pwdata;
                    REG_INV_Z:   inv_reg[2]   <= pwdata;
                    default:     ;
                endcase
            end
        end
    end

    gsw_front #(.DIMS(DIMS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .push      (push),
        .full      (full),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .item_push (item_push),
        .item_full (item_full),
        .item      (item)
    );

    gsw_fifo #(.W(ITEM_W), .DEPTH(4)) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (item_push),
        .wdata (item),
        .full  (item_full),
        .pop   (q_pop),
        .rdata (q_item),
        .empty (q_empty)
    );

    gsw_back #(.DIMS(DIMS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .o_full  (o_full),
        .o_push  (o_push),
        .o_res   (o_res)
    );

    gsw_fifo #(.W(RES_W), .DEPTH(4)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (o_push),
        .wdata (o_res),
        .full  (o_full),
        .pop   (pop),
        .rdata (res),
        .empty (empty)
    );

    assign in_domain  = res.in_domain;
    assign element_id = res.element_id;
    assign corner     = res.corner;
    assign node_id    = res.node_id;
    assign weight     = res.weight;
    assign grad_x     = res.grad[0];
    assign grad_y     = res.grad[1];
    assign grad_z     = res.grad[2];
    assign last       = res.last;

endmodule

// ===== rtl/gsw_fifo.sv =====
// Small register FIFO with full and empty flags.
module gsw_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] rdata,
    output logic         empty
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/gsw_front.sv =====
// Front pipeline: scale position, find cell and fraction, check domain, build base ids.
module gsw_front import gsw_pkg::*; #(
    parameter int DIMS = 3
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gsw_cfg_t                cfg,
    input  logic                    push,
    output logic                    full,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [POS_W-1:0] pos_z,
    output logic                    item_push,
    input  logic                    item_full,
    output gsw_item_t               item
);

    logic [NAXES-1:0][POS_W-1:0] pos;
    logic                        adv;

    logic                         s1_v_reg;
    logic [NAXES-1:0][63:0]       s1_u_reg, s1_u_next;
    logic [NAXES-1:0]             s1_neg_reg;

    logic                         s2_v_reg;
    logic                         s2_inside_reg, s2_inside_next;
    logic [NAXES-1:0][CIDX_W-1:0] s2_cidx_reg, s2_cidx_next;
    logic [NAXES-1:0][FRAC_W-1:0] s2_frac_reg, s2_frac_next;

    logic                         s3_v_reg;
    logic                         s3_inside_reg;
    logic [NAXES-1:0][FRAC_W-1:0] s3_frac_reg;
    logic [CIDX_W-1:0]            s3_i_reg;
    logic [20:0]                  s3_pj_reg, s3_pj_next;
    logic [ELEM_W-1:0]            s3_pk_reg, s3_pk_next;
    logic [20:0]                  s3_nj_reg, s3_nj_next;
    logic [NODE_W-1:0]            s3_nk_reg, s3_nk_next;

    assign pos       = {pos_z, pos_y, pos_x};
    assign adv       = !s3_v_reg || !item_full;
    assign full      = !adv;
    assign item_push = s3_v_reg && !item_full;

    always_comb
    begin
        logic [NAXES-1:0] outside;
        outside = '0;
        for (int d = 0; d < NAXES; d++)
        begin
            s1_u_next[d] = 64'(pos[d]) * 64'(cfg.inv[d]);
        end
        for (int d = 0; d < NAXES; d++)
        begin
            if (d < DIMS)
            begin
                outside[d] = s1_neg_reg[d] ||
                             (s1_u_reg[d][63:32] >= 32'(cfg.eff_cells[d]));
                s2_cidx_next[d] = s1_u_reg[d][32 +: CIDX_W];
                s2_frac_next[d] = s1_u_reg[d][31:16];
            end
            else
            begin
                s2_cidx_next[d] = '0;
                s2_frac_next[d] = '0;
            end
        end
        s2_inside_next = ~|outside;
        s3_pj_next = 21'(s2_cidx_reg[1]) * 21'(cfg.eff_cells[0]);
        s3_pk_next = ELEM_W'(32'(s2_cidx_reg[2]) * 32'(cfg.cxy));
        s3_nj_next = 21'(s2_cidx_reg[1]) * 21'(cfg.sx1);
        s3_nk_next = NODE_W'(32'(s2_cidx_reg[2]) * 32'(cfg.sxy1));
    end

    always_comb
    begin
        item.in_grid   = s3_inside_reg;
        item.frac      = s3_frac_reg;
        item.elem      = ELEM_W'(s3_i_reg) + ELEM_W'(s3_pj_reg) + s3_pk_reg;
        item.node_base = NODE_W'(s3_i_reg) + NODE_W'(s3_nj_reg) + s3_nk_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= push;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_u_reg <= s1_u_next;
            for (int d = 0; d < NAXES; d++)
            begin
                s1_neg_reg[d] <= pos[d][POS_W-1];
            end
            s2_inside_reg <= s2_inside_next;
            s2_cidx_reg   <= s2_cidx_next;
            s2_frac_reg   <= s2_frac_next;
            s3_inside_reg <= s2_inside_reg;
            s3_frac_reg   <= s2_frac_reg;
            s3_i_reg      <= s2_cidx_reg[0];
            s3_pj_reg     <= s3_pj_next;
            s3_pk_reg     <= s3_pk_next;
            s3_nj_reg     <= s3_nj_next;
            s3_nk_reg     <= s3_nk_next;
        end
    end

endmodule

// ===== rtl/gsw_back.sv =====
// Back pipeline: step through cell corners, form weights, gradients and node ids.
module gsw_back import gsw_pkg::*; #(
    parameter int DIMS = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    input  gsw_cfg_t    cfg,
    input  logic        q_empty,
    input  gsw_item_t   q_item,
    output logic        q_pop,
    input  logic        o_full,
    output logic        o_push,
    output gsw_result_t o_res
);

    localparam int                  NCORN       = 1 << DIMS;
    localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(NCORN - 1);

    logic                adv;
    logic                issue;
    logic [CORNER_W-1:0] cnt_reg, cnt_next;

    logic                           b1_v_reg;
    logic                           b1_inside_reg;
    logic [CORNER_W-1:0]            b1_corner_reg, b1_corner_next;
    logic                           b1_last_reg, b1_last_next;
    logic [ELEM_W-1:0]              b1_elem_reg, b1_elem_next;
    logic [NODE_W-1:0]              b1_node_reg, b1_node_next;
    logic [NAXES-1:0][WEIGHT_W-1:0] b1_fac_reg, b1_fac_next;
    logic [33:0]                    b1_p01_reg, b1_p01_next;
    logic [33:0]                    b1_p02_reg, b1_p02_next;
    logic [33:0]                    b1_p12_reg, b1_p12_next;
    logic [NAXES-1:0]               b1_fz_reg, b1_fz_next;

    logic                           b2_v_reg;
    logic                           b2_inside_reg;
    logic [CORNER_W-1:0]            b2_corner_reg;
    logic                           b2_last_reg;
    logic [ELEM_W-1:0]              b2_elem_reg;
    logic [NODE_W-1:0]              b2_node_reg;
    logic [WEIGHT_W-1:0]            b2_weight_reg, b2_weight_next;
    logic [NAXES-1:0][48:0]         b2_raw_reg, b2_raw_next;
    logic [NAXES-1:0]               b2_zero_reg, b2_zero_next;

    assign adv    = !b2_v_reg || !o_full;
    assign issue  = adv && !q_empty;
    assign q_pop  = issue && (!q_item.in_grid || (cnt_reg == LAST_CORNER));
    assign o_push = b2_v_reg && !o_full;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (issue)
        begin
            cnt_next = q_pop ? '0 : cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        for (int d = 0; d < NAXES; d++)
        begin
            b1_fac_next[d] = cnt_reg[d] ? WEIGHT_W'(q_item.frac[d])
                                        : ONE_Q16 - WEIGHT_W'(q_item.frac[d]);
            b1_fz_next[d]  = (q_item.frac[d] == '0);
        end
        b1_p01_next = 34'(b1_fac_next[0]) * 34'(b1_fac_next[1]);
        b1_p02_next = 34'(b1_fac_next[0]) * 34'(b1_fac_next[2]);
        b1_p12_next = 34'(b1_fac_next[1]) * 34'(b1_fac_next[2]);
        if (q_item.in_grid)
        begin
            b1_corner_next = cnt_reg;
            b1_last_next   = (cnt_reg == LAST_CORNER);
            b1_elem_next   = q_item.elem;
            b1_node_next   = q_item.node_base + NODE_W'(cnt_reg[0])
                           + (cnt_reg[1] ? NODE_W'(cfg.sx1) : '0)
                           + (cnt_reg[2] ? NODE_W'(cfg.sxy1) : '0);
        end
        else
        begin
            b1_corner_next = '0;
            b1_last_next   = 1'b1;
            b1_elem_next   = '0;
            b1_node_next   = '0;
        end
    end

    always_comb
    begin
        logic [NAXES-1:0][WEIGHT_W-1:0] oth;
        logic [50:0]                    wp;
        wp = '0;
        if (DIMS == 3)
        begin
            wp             = 51'(b1_p01_reg) * 51'(b1_fac_reg[2]);
            b2_weight_next = WEIGHT_W'((wp + (51'd1 << 31)) >> 32);
            oth[0]         = WEIGHT_W'((b1_p12_reg + 34'h8000) >> 16);
            oth[1]         = WEIGHT_W'((b1_p02_reg + 34'h8000) >> 16);
            oth[2]         = WEIGHT_W'((b1_p01_reg + 34'h8000) >> 16);
        end
        else if (DIMS == 2)
        begin
            b2_weight_next = WEIGHT_W'((b1_p01_reg + 34'h8000) >> 16);
            oth[0]         = b1_fac_reg[1];
            oth[1]         = b1_fac_reg[0];
            oth[2]         = ONE_Q16;
        end
        else
        begin
            b2_weight_next = b1_fac_reg[0];
            oth            = {NAXES{ONE_Q16}};
        end
        for (int d = 0; d < NAXES; d++)
        begin
            b2_raw_next[d]  = 49'(cfg.inv[d]) * 49'(oth[d]);
            b2_zero_next[d] = (d >= DIMS) || !b1_inside_reg ||
                              (!b1_corner_reg[d] && b1_fz_reg[d]);
        end
    end

    always_comb
    begin
        logic [33:0] mag;
        o_res.in_domain  = b2_inside_reg;
        o_res.element_id = b2_elem_reg;
        o_res.corner     = b2_corner_reg;
        o_res.node_id    = b2_node_reg;
        o_res.weight     = b2_inside_reg ? b2_weight_reg : '0;
        o_res.last       = b2_last_reg;
        for (int d = 0; d < NAXES; d++)
        begin
            mag = 34'((b2_raw_reg[d] + 49'h8000) >> 16);
            if (b2_zero_reg[d])
            begin
                o_res.grad[d] = '0;
            end
            else if (!b2_corner_reg[d])
            begin
                o_res.grad[d] = (mag >= 34'h080000000) ? 32'h80000000 : 32'd0 - mag[31:0];
            end
            else
            begin
                o_res.grad[d] = (mag > 34'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            b1_v_reg <= 1'b0;
            b2_v_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (adv)
            begin
                b1_v_reg <= issue;
                b2_v_reg <= b1_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b1_inside_reg <= q_item.in_grid;
            b1_corner_reg <= b1_corner_next;
            b1_last_reg   <= b1_last_next;
            b1_elem_reg   <= b1_elem_next;
            b1_node_reg   <= b1_node_next;
            b1_fac_reg    <= b1_fac_next;
            b1_p01_reg    <= b1_p01_next;
            b1_p02_reg    <= b1_p02_next;
            b1_p12_reg    <= b1_p12_next;
            b1_fz_reg     <= b1_fz_next;
            b2_inside_reg <= b1_inside_reg;
            b2_corner_reg <= b1_corner_reg;
            b2_last_reg   <= b1_last_reg;
            b2_elem_reg   <= b1_elem_reg;
            b2_node_reg   <= b1_node_reg;
            b2_weight_reg <= b2_weight_next;
            b2_raw_reg    <= b2_raw_next;
            b2_zero_reg   <= b2_zero_next;
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the trilinear grid shape weight block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import gsw_pkg::*;

    localparam int AXES      = 3;
    localparam int MAX_CELLS = 1024;
    localparam int CORNERS   = 8;
    localparam int HOLDOFF   = 400;

    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        flagged;
    } position_row_t;

    typedef struct packed {
        logic [31:0] cells_x;
        logic [31:0] cells_y;
        logic [31:0] cells_z;
        logic [31:0] inv_x;
        logic [31:0] inv_y;
        logic [31:0] inv_z;
    } grid_setting_t;

    localparam position_row_t DIRECTED_POSITIONS [16] = '{
        {32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0},
        {32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 1'b0},
        {32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 1'b0},
        {32'h0000_0000, 32'h0000_FFFF, 32'h0000_0001, 1'b0},
        {32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b1},
        {32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1'b1},
        {32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1'b1},
        {32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1},
        {32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1},
        {32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b1},
        {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1},
        {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
        {32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b0},
        {32'h0000_C000, 32'h0000_4000, 32'h0000_0000, 1'b0},
        {32'h0000_0000, 32'h0000_8000, 32'h0000_0000, 1'b0},
        {32'h0000_FFFF, 32'h0000_0000, 32'h0000_8000, 1'b0}
    };

    localparam grid_setting_t FIXED_SETTINGS [5] = '{
        {32'd4,    32'd3,    32'd2,    32'h0001_0000, 32'h0001_0000, 32'h0001_0000},
        {32'd1024, 32'd1024, 32'd1024, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        {32'd2047, 32'd1100, 32'd1025, 32'h0000_0001, 32'h0000_8000, 32'h0002_0000},
        {32'd0,    32'd5,    32'd5,    32'h0001_0000, 32'h0001_0000, 32'h0001_0000},
        {32'd7,    32'd9,    32'd11,   32'h0001_8000, 32'h0000_0000, 32'h0000_9000}
    };

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [DATA_W-1:0]        pwdata;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     push;
    logic                     full;
    logic [POS_W-1:0]         pos_x;
    logic [POS_W-1:0]         pos_y;
    logic [POS_W-1:0]         pos_z;
    logic                     pop;
    logic                     empty;
    logic                     in_domain;
    logic [ELEM_W-1:0]        element_id;
    logic [CORNER_W-1:0]      corner;
    logic [NODE_W-1:0]        node_id;
    logic [WEIGHT_W-1:0]      weight;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic signed [GRAD_W-1:0] grad_z;
    logic                     last;

    logic [CELL_W-1:0] grid_cells [AXES];
    logic [INV_W-1:0]  grid_inv   [AXES];
    gsw_result_t       expected_beats [$];
    int                mismatches = 0;
    int                beats_checked = 0;
    bit                calm = 1'b0;
    bit                pop_steady = 1'b0;
    bit                holdoff_wanted = 1'b0;
    bit                holdoff_done = 1'b0;

    always #6 clk = ~clk;

    trilinear_grid_shape_weights #(
        .DIMS      (3),
        .MAX_CELLS (MAX_CELLS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .push       (push),
        .full       (full),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .pop        (pop),
        .empty      (empty),
        .in_domain  (in_domain),
        .element_id (element_id),
        .corner     (corner),
        .node_id    (node_id),
        .weight     (weight),
        .grad_x     (grad_x),
        .grad_y     (grad_y),
        .grad_z     (grad_z),
        .last       (last)
    );

    function automatic logic [63:0] effective_cells(input int d);
        if (grid_cells[d] > MAX_CELLS)
        begin
            return 64'(MAX_CELLS);
        end
        return {53'h0, grid_cells[d]};
    endfunction

    function automatic void queue_beat(input gsw_result_t b);
        expected_beats = {expected_beats, b};
    endfunction

    function automatic void predict_corner_beats(input logic [31:0] px, input logic [31:0] py,
                                                 input logic [31:0] pz);
        logic [31:0] pos [AXES];
        logic [63:0] cnt [AXES];
        logic [63:0] cidx [AXES];
        logic [63:0] fac [AXES];
        logic [15:0] frac [AXES];
        logic [63:0] u, elem, node, nstride, wp, others, mag;
        logic        in_grid, up;
        gsw_result_t beat;
        int          n, d, j;
        pos[0] = px;
        pos[1] = py;
        pos[2] = pz;
        in_grid = 1'b1;
        for (d = 0; d < AXES; d++)
        begin
            cnt[d]  = effective_cells(d);
            cidx[d] = '0;
            frac[d] = '0;
        end
        for (d = 0; d < AXES; d++)
        begin
            if (pos[d][31])
            begin
                in_grid = 1'b0;
            end
            else
            begin
                u = {32'h0, pos[d]} * {32'h0, grid_inv[d]};
                if ({32'h0, u[63:32]} >= cnt[d])
                begin
                    in_grid = 1'b0;
                end
                else
                begin
                    cidx[d] = {32'h0, u[63:32]};
                    frac[d] = u[31:16];
                end
            end
        end
        beat = '0;
        if (!in_grid)
        begin
            beat.last = 1'b1;
            queue_beat(beat);
            return;
        end
        elem = cidx[0] + cidx[1] * cnt[0] + cidx[2] * cnt[0] * cnt[1];
        for (n = 0; n < CORNERS; n++)
        begin
            node    = 64'd0;
            nstride = 64'd1;
            wp      = 64'd1;
            for (d = 0; d < AXES; d++)
            begin
                up      = n[d];
                fac[d]  = up ? {48'h0, frac[d]} : 64'd65536 - {48'h0, frac[d]};
                wp      = wp * fac[d];
                node    = node + (cidx[d] + {63'h0, up}) * nstride;
                nstride = nstride * (cnt[d] + 64'd1);
            end
            beat.in_domain  = 1'b1;
            beat.element_id = elem[ELEM_W-1:0];
            beat.corner     = n[CORNER_W-1:0];
            beat.node_id    = node[NODE_W-1:0];
            u               = (wp + 64'h8000_0000) >> 32;
            beat.weight     = u[WEIGHT_W-1:0];
            for (d = 0; d < AXES; d++)
            begin
                up = n[d];
                if (!up && frac[d] == 16'h0)
                begin
                    beat.grad[d] = '0;
                end
                else
                begin
                    others = 64'd1;
                    for (j = 0; j < AXES; j++)
                    begin
                        if (j != d)
                        begin
                            others = others * fac[j];
                        end
                    end
                    others = (others + 64'h8000) >> 16;
                    mag    = ({32'h0, grid_inv[d]} * others + 64'h8000) >> 16;
                    if (!up)
                    begin
                        beat.grad[d] = (mag >= 64'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
                    end
                    else
                    begin
                        beat.grad[d] = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
                    end
                end
            end
            beat.last = (n == CORNERS - 1);
            queue_beat(beat);
        end
    endfunction

    function automatic logic [31:0] pick_position(input int d);
        logic [63:0] cnt, lim;
        int unsigned pick;
        cnt = effective_cells(d);
        if (cnt == 0)
        begin
            lim = 0;
        end
        else if (grid_inv[d] == 0)
        begin
            lim = 64'h7FFF_FFFF;
        end
        else
        begin
            lim = ((cnt << 32) - 1) / {32'h0, grid_inv[d]};
        end
        if (lim > 64'h7FFF_FFFF)
        begin
            lim = 64'h7FFF_FFFF;
        end
        pick = $urandom_range(0, 9);
        if (pick < 8)
        begin
            return $urandom_range(0, lim[31:0]);
        end
        if (pick == 8)
        begin
            return lim[31:0] + $urandom_range(0, 1);
        end
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_cells();
        int unsigned mode;
        mode = $urandom_range(0, 5);
        if (mode < 4)
        begin
            return $urandom_range(1, 12);
        end
        if (mode == 4)
        begin
            return $urandom_range(1, 2047);
        end
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_inv();
        int unsigned mode;
        mode = $urandom_range(0, 5);
        if (mode < 4)
        begin
            return $urandom_range(32'h0000_4000, 32'h0006_0000);
        end
        if (mode == 4)
        begin
            return $urandom;
        end
        return $urandom_range(0, 3);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("mismatch at beat %0d: %s got %0h want %0h", beats_checked, what, got, want);
    endtask

    task automatic check_result_beat();
        gsw_result_t want;
        if (expected_beats.size() == 0)
        begin
            report_mismatch("beat with nothing expected", 64'(node_id), 64'h0);
        end
        else
        begin
            want = expected_beats.pop_front();
            if (in_domain !== want.in_domain)
                report_mismatch("in_domain", 64'(in_domain), 64'(want.in_domain));
            if (element_id !== want.element_id)
                report_mismatch("element_id", 64'(element_id), 64'(want.element_id));
            if (corner !== want.corner)
                report_mismatch("corner", 64'(corner), 64'(want.corner));
            if (node_id !== want.node_id)
                report_mismatch("node_id", 64'(node_id), 64'(want.node_id));
            if (weight !== want.weight)
                report_mismatch("weight", 64'(weight), 64'(want.weight));
            if (grad_x !== want.grad[0])
                report_mismatch("grad_x", 64'(grad_x), 64'(want.grad[0]));
            if (grad_y !== want.grad[1])
                report_mismatch("grad_y", 64'(grad_y), 64'(want.grad[1]));
            if (grad_z !== want.grad[2])
                report_mismatch("grad_z", 64'(grad_z), 64'(want.grad[2]));
            if (last !== want.last)
                report_mismatch("last", 64'(last), 64'(want.last));
        end
        beats_checked++;
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        readback = '0;
        case (idx)
            REG_CELLS_X:
            begin
                grid_cells[0] = value[CELL_W-1:0];
                readback      = 32'(value[CELL_W-1:0]);
            end
            REG_CELLS_Y:
            begin
                grid_cells[1] = value[CELL_W-1:0];
                readback      = 32'(value[CELL_W-1:0]);
            end
            REG_CELLS_Z:
            begin
                grid_cells[2] = value[CELL_W-1:0];
                readback      = 32'(value[CELL_W-1:0]);
            end
            REG_INV_X:
            begin
                grid_inv[0] = value;
                readback    = value;
            end
            REG_INV_Y:
            begin
                grid_inv[1] = value;
                readback    = value;
            end
            REG_INV_Z:
            begin
                grid_inv[2] = value;
                readback    = value;
            end
            default:     ;
        endcase
        @(posedge clk);
        psel <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== readback)
            report_mismatch("register read", 64'(prdata), 64'(readback));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_grid_setting(input grid_setting_t s);
        write_register(REG_CELLS_X, s.cells_x);
        write_register(REG_CELLS_Y, s.cells_y);
        write_register(REG_CELLS_Z, s.cells_z);
        write_register(REG_INV_X, s.inv_x);
        write_register(REG_INV_Y, s.inv_y);
        write_register(REG_INV_Z, s.inv_z);
        write_register($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom);
    endtask

    task automatic send_position(input logic [31:0] px, input logic [31:0] py,
                                 input logic [31:0] pz, input bit flagged, input bit gaps_on);
        gsw_result_t outside_beat;
        outside_beat      = '0;
        outside_beat.last = 1'b1;
        push  <= 1'b1;
        pos_x <= px;
        pos_y <= py;
        pos_z <= pz;
        do @(posedge clk); while (full);
        if (flagged)
            queue_beat(outside_beat);
        else
            predict_corner_beats(px, py, pz);
        if (gaps_on && !calm && $urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
                check_result_beat();
            if (holdoff_wanted && !holdoff_done)
            begin
                hold_left    = HOLDOFF;
                holdoff_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (!calm && !pop_steady && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    initial
    begin
        grid_setting_t s;
        bit            gaps_on;
        int            i, k, r;
        for (i = 0; i < AXES; i++)
        begin
            grid_cells[i] = 1;
            grid_inv[i]   = 32'h0001_0000;
        end
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        push    <= 1'b0;
        pos_x   <= '0;
        pos_y   <= '0;
        pos_z   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < 16; i++)
        begin
            send_position(DIRECTED_POSITIONS[i].x, DIRECTED_POSITIONS[i].y,
                          DIRECTED_POSITIONS[i].z, DIRECTED_POSITIONS[i].flagged, 1'b1);
        end
        drain_results();

        for (k = 0; k < 5; k++)
        begin
            apply_grid_setting(FIXED_SETTINGS[k]);
            gaps_on    = ($urandom_range(0, 3) != 0);
            pop_steady = ($urandom_range(0, 3) == 0);
            for (i = 0; i < 30; i++)
                send_position(pick_position(0), pick_position(1), pick_position(2), 1'b0, gaps_on);
            drain_results();
        end

        for (r = 0; r < 8; r++)
        begin
            s.cells_x = pick_cells();
            s.cells_y = pick_cells();
            s.cells_z = pick_cells();
            s.inv_x   = pick_inv();
            s.inv_y   = pick_inv();
            s.inv_z   = pick_inv();
            apply_grid_setting(s);
            gaps_on    = ($urandom_range(0, 3) != 0);
            pop_steady = ($urandom_range(0, 3) == 0);
            if (r == 1)
                holdoff_wanted = 1'b1;
            if (r == 7)
                calm = 1'b1;
            for (i = 0; i < 40; i++)
                send_position(pick_position(0), pick_position(1), pick_position(2), 1'b0, gaps_on);
            drain_results();
        end

        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    initial
    begin
        #6_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
